### hw/rtl/lz_flag_byte_decompressor_unit_assert.svh
// Assertion macros used by the decompressor back copy engine.
// Bodies compile away when SYNTHESIS is defined.
`ifndef LZ_FLAG_BYTE_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ_FLAG_BYTE_DECOMPRESSOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LZFD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("lzfd assertion failed");
`define LZFD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("lzfd forbidden condition seen");
`else
`define LZFD_ASSERT(lbl, clk, rst_n, prop)
`define LZFD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hw/rtl/lzfd_pkg.sv
// Shared types and constants of the flag-byte LZ decompressor.
// No dependencies; used by every module of the block but lzfd_ram.
package lzfd_pkg;
	localparam int HISTORY_DEPTH_DEF = 4096;
	localparam int COUNT_BITS_DEF    = 24;
	localparam int LEN_W             = 24;  // output_length register width
	localparam int DIST_W            = 12;
	localparam int CNT_W             = 5;   // copy count, 1..17
	localparam int FIFO_DEPTH        = 4;
	localparam int MIN_MATCH         = 2;
	localparam int FLAG_COUNT        = 8;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_ERR
	} cmd_kind_t;

	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_RAM,
		SRC_REP,
		SRC_ERR
	} src_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         lit_byte;
		logic [DIST_W-1:0]  copy_dist;
		logic [CNT_W-1:0]   count;
		logic               done;
	} cmd_t;
endpackage

### hw/rtl/lzfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### hw/rtl/lzfd_cmd_fifo.sv
// Short command queue between the front parser and the back copy engine.
// Depends on lzfd_pkg.
module lzfd_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lzfd_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output lzfd_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import lzfd_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	cmd_t           slot_q [FIFO_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    fill_q;

	assign full    = (fill_q == (PW+1)'(FIFO_DEPTH));
	assign empty   = (fill_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule

### hw/rtl/lzfd_front.sv
// Front parser: takes compressed bytes, tracks flags, tokens and the output
// count, and queues literal, copy and error commands. Depends on lzfd_pkg.
module lzfd_front #(
	parameter int COUNT_BITS = lzfd_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        stream_start,
	input  logic [lzfd_pkg::LEN_W-1:0]  output_length,
	output logic                        push,
	output lzfd_pkg::cmd_t              push_cmd,
	input  logic                        fifo_full
);
	import lzfd_pkg::*;

	localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
	localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

	logic [7:0]            flag_bits_q;
	logic [3:0]            flags_left_q;
	logic                  token_phase_q;
	logic [7:0]            token_low_q;
	logic [COUNT_BITS-1:0] produced_q;
	logic                  finished_q;

	logic [7:0]            fb, fb_n;
	logic [3:0]            fl, fl_n;
	logic                  tp, tp_n;
	logic [7:0]            tl, tl_n;
	logic [COUNT_BITS-1:0] pc, pc_n;
	logic                  fin, fin_n;

	logic [CMP_W-1:0]      pc_ext;
	logic [CMP_W-1:0]      olen_ext;
	logic [CMP_W-1:0]      remain;
	logic                  olen_fits;
	logic [COUNT_BITS-1:0] pc_inc;
	logic [DIST_W-1:0]     copy_dist;
	logic [CNT_W-1:0]      len_full;
	logic [CNT_W-1:0]      n_copy;
	logic                  copy_done;
	logic                  accept;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		// a stream start clears the stream state before this byte is parsed
		fb  = stream_start ? '0 : flag_bits_q;
		fl  = stream_start ? '0 : flags_left_q;
		tp  = stream_start ? 1'b0 : token_phase_q;
		tl  = stream_start ? '0 : token_low_q;
		pc  = stream_start ? '0 : produced_q;
		fin = stream_start ? 1'b0 : finished_q;

		pc_ext    = CMP_W'(pc);
		olen_ext  = CMP_W'(output_length);
		olen_fits = (olen_ext <= CNT_MAX);
		remain    = olen_ext - pc_ext;
		pc_inc    = pc + 1'b1;
		copy_dist = {data_byte, tl[7:4]};
		len_full  = CNT_W'(tl[3:0]) + CNT_W'(MIN_MATCH);
		// a count that wraps never reaches a length beyond its range
		copy_done = olen_fits && (remain <= CMP_W'(len_full));
		n_copy    = copy_done ? remain[CNT_W-1:0] : len_full;

		fb_n  = fb;
		fl_n  = fl;
		tp_n  = tp;
		tl_n  = tl;
		pc_n  = pc;
		fin_n = fin;
		push  = 1'b0;
		push_cmd = '{kind: CMD_LIT, lit_byte: data_byte, copy_dist: copy_dist,
			count: n_copy, done: 1'b0};

		if (!fin) begin
			if (fl == '0) begin
				fin_n = (pc_ext >= olen_ext);
				fb_n  = data_byte;
				fl_n  = 4'(FLAG_COUNT);
			end else if (pc_ext >= olen_ext) begin
				fin_n = 1'b1;
			end else if (fb[0]) begin
				pc_n  = pc_inc;
				fb_n  = fb >> 1;
				fl_n  = fl - 1'b1;
				fin_n = (CMP_W'(pc_inc) >= olen_ext);
				push  = accept;
				push_cmd.kind = CMD_LIT;
				push_cmd.done = fin_n;
			end else if (!tp) begin
				tl_n = data_byte;
				tp_n = 1'b1;
			end else begin
				tp_n = 1'b0;
				tl_n = '0;
				fb_n = fb >> 1;
				fl_n = fl - 1'b1;
				push = accept;
				if (copy_dist == '0 || CMP_W'(copy_dist) > pc_ext) begin
					fin_n = 1'b1;
					push_cmd.kind = CMD_ERR;
				end else begin
					pc_n  = pc + COUNT_BITS'(n_copy);
					fin_n = copy_done;
					push_cmd.kind = CMD_COPY;
					push_cmd.done = copy_done;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bits_q   <= '0;
			flags_left_q  <= '0;
			token_phase_q <= 1'b0;
			token_low_q   <= '0;
			produced_q    <= '0;
			finished_q    <= 1'b0;
		end else if (accept) begin
			flag_bits_q   <= fb_n;
			flags_left_q  <= fl_n;
			token_phase_q <= tp_n;
			token_low_q   <= tl_n;
			produced_q    <= pc_n;
			finished_q    <= fin_n;
		end
	end
endmodule

### hw/rtl/lzfd_back.sv
// Back copy engine: expands queued commands into output bytes, one per cycle
// unless stalled, through the history RAM. Depends on lzfd_pkg, lzfd_ram and the assert header.
`include "lz_flag_byte_decompressor_unit_assert.svh"
module lzfd_back #(
	parameter int HISTORY_DEPTH = lzfd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fifo_empty,
	input  lzfd_pkg::cmd_t cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           run_last,
	output logic           stream_done,
	output logic           bad_distance
);
	import lzfd_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
		addr_inc = (a == AW'(HISTORY_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	// copy in progress
	logic             busy_q;
	logic [CNT_W-1:0] rem_q;
	logic [AW-1:0]    src_q;
	logic             done_q;
	logic             rep_q;
	logic [AW-1:0]    ip_q;      // history slot of the next issued byte
	logic [7:0]       last_byte_q;

	// issue stage
	logic             valid_s1;
	src_kind_t        kind_s1;
	logic [7:0]       lit_s1;
	logic             last_s1;
	logic             done_s1;
	logic [AW-1:0]    waddr_s1;

	// output register
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_last_q;
	logic             stream_done_q;
	logic             bad_distance_q;

	logic             s2_free, s1_free, move12, issue;
	logic             iss_valid, iss_last, iss_done;
	src_kind_t        iss_kind;
	logic [AW-1:0]    iss_raddr;
	logic [AW:0]      ip_ext, dist_ext, src_sum;
	logic [AW-1:0]    src_first;
	logic [7:0]       rdata;
	logic [7:0]       byte_val;
	logic             ram_we, ram_re;

	assign s2_free = !out_valid_q || out_ready;
	assign move12  = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || move12;

	always_comb begin
		ip_ext   = {1'b0, ip_q};
		dist_ext = (AW+1)'(cmd.copy_dist);
		src_sum  = (ip_ext >= dist_ext) ? ip_ext - dist_ext
			: ip_ext + (AW+1)'(HISTORY_DEPTH) - dist_ext;
		src_first = src_sum[AW-1:0];
	end

	always_comb begin
		iss_valid = 1'b0;
		iss_kind  = SRC_ERR;
		iss_raddr = src_q;
		iss_last  = 1'b1;
		iss_done  = 1'b0;
		pop       = 1'b0;
		if (busy_q) begin
			iss_valid = 1'b1;
			iss_kind  = rep_q ? SRC_REP : SRC_RAM;
			iss_last  = (rem_q == CNT_W'(1));
			iss_done  = iss_last && done_q;
		end else if (!fifo_empty) begin
			iss_valid = 1'b1;
			pop       = s1_free;
			case (cmd.kind)
				CMD_LIT: begin
					iss_kind = SRC_LIT;
					iss_done = cmd.done;
				end
				CMD_COPY: begin
					// distance one repeats the byte still being written
					iss_kind  = (cmd.copy_dist == DIST_W'(1)) ? SRC_REP : SRC_RAM;
					iss_raddr = src_first;
					iss_last  = (cmd.count == CNT_W'(1));
					iss_done  = iss_last && cmd.done;
				end
				default: begin
					iss_kind = SRC_ERR;
				end
			endcase
		end
	end

	assign issue  = iss_valid && s1_free;
	assign ram_re = issue && (iss_kind == SRC_RAM);

	always_comb begin
		case (kind_s1)
			SRC_LIT: byte_val = lit_s1;
			SRC_RAM: byte_val = rdata;
			SRC_REP: byte_val = last_byte_q;
			default: byte_val = '0;
		endcase
	end

	assign ram_we = move12 && (kind_s1 != SRC_ERR);

	lzfd_ram #(
		.WIDTH (8),
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_s1),
		.wdata (byte_val),
		.re    (ram_re),
		.raddr (iss_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			src_q       <= '0;
			done_q      <= 1'b0;
			rep_q       <= 1'b0;
			ip_q        <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (busy_q) begin
					rem_q <= rem_q - 1'b1;
					src_q <= addr_inc(src_q);
					if (rem_q == CNT_W'(1)) begin
						busy_q <= 1'b0;
					end
				end else if (cmd.kind == CMD_COPY && cmd.count != CNT_W'(1)) begin
					busy_q <= 1'b1;
					rem_q  <= cmd.count - 1'b1;
					src_q  <= addr_inc(src_first);
					done_q <= cmd.done;
					rep_q  <= (cmd.copy_dist == DIST_W'(1));
				end
				if (iss_kind != SRC_ERR) begin
					ip_q <= addr_inc(ip_q);
				end
			end
			if (s1_free) begin
				valid_s1 <= iss_valid;
			end
			if (s2_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1  <= iss_kind;
			lit_s1   <= cmd.lit_byte;
			last_s1  <= iss_last;
			done_s1  <= iss_done;
			waddr_s1 <= ip_q;
		end
		if (ram_we) begin
			last_byte_q <= byte_val;
		end
		if (move12) begin
			out_byte_q     <= byte_val;
			run_last_q     <= last_s1;
			stream_done_q  <= done_s1;
			bad_distance_q <= (kind_s1 == SRC_ERR);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign run_last     = run_last_q;
	assign stream_done  = stream_done_q;
	assign bad_distance = bad_distance_q;

	`LZFD_ASSERT_NEVER(a_busy_no_rem, clk, arst_n, busy_q && rem_q == '0)
	`LZFD_ASSERT(a_err_is_last, clk, arst_n, (valid_s1 && kind_s1 == SRC_ERR) |-> (last_s1 && !done_s1))
	`LZFD_ASSERT(a_done_is_last, clk, arst_n, (out_valid_q && stream_done_q) |-> run_last_q)
	`LZFD_ASSERT_NEVER(a_pop_while_busy, clk, arst_n, busy_q && pop)
endmodule

### hw/rtl/lz_flag_byte_decompressor_unit.sv
// Top level of the flag-byte LZ decompressor with 12-bit distance.
// Depends on lzfd_pkg, lzfd_front, lzfd_cmd_fifo and lzfd_back.
//
// Usage:
//   Compressed bytes enter on in_valid/in_ready with data_byte; stream_start
//   marks the first byte of a stream. Decompressed bytes leave on
//   out_valid/out_ready with out_byte, run_last, stream_done, bad_distance.
//   output_length is written through cfg_we/cfg_wdata while the block is idle.
//   The front parses one byte per cycle while the command queue (4 entries)
//   has room; flag bytes and token low bytes give no result.
//   The back produces one result per cycle while the receiver is ready: a literal
//   gives one result and a copy token of n bytes gives n results (1..17). The
//   next command is taken from the queue only after a copy's last byte issues.
//   A result passes through the queue, the issue stage (issue/RAM read) and
//   the output register.
//   A stalled receiver holds the output register; the issue stage and then
//   the queue fill, and in_ready drops once the queue is full.
//   Reset clears all counters and the queue and sets output_length to 0.
//   History contents are undefined after reset and are never read before
//   being written, so no clearing pass is done.
module lz_flag_byte_decompressor_unit #(
	parameter int HISTORY_DEPTH = lzfd_pkg::HISTORY_DEPTH_DEF,
	parameter int COUNT_BITS    = lzfd_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lzfd_pkg::LEN_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       stream_start,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       run_last,
	output logic                       stream_done,
	output logic                       bad_distance
);
	import lzfd_pkg::*;

	logic [LEN_W-1:0] output_length_q;
	logic             push, pop, fifo_full, fifo_empty;
	cmd_t             push_cmd, pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_length_q <= '0;
		end else if (cfg_we) begin
			output_length_q <= cfg_wdata;
		end
	end

	lzfd_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.stream_start  (stream_start),
		.output_length (output_length_q),
		.push          (push),
		.push_cmd      (push_cmd),
		.fifo_full     (fifo_full)
	);

	lzfd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (fifo_empty)
	);

	lzfd_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (fifo_empty),
		.cmd          (pop_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.stream_done  (stream_done),
		.bad_distance (bad_distance)
	);
endmodule
